FILE: rtl/core/bafs_pkg.sv
// ----------------------------------------------------------------------------
// bafs_pkg: shared types and constants for the arbitration frame sender
// Action and status codes, frame store sizing and derived widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bafs_pkg;

  // Frame store depth and derived widths
  localparam int MaxFrame = 16;
  localparam int StoreIdxW = (MaxFrame > 1) ? $clog2(MaxFrame) : 1;
  localparam int CountW = $clog2(MaxFrame + 1);

  // Reset value of the receive limit register
  localparam logic [4:0] RxLengthReset = 5'd10;

  // Slot positions: sync slot, then eight data bits
  localparam logic [3:0] SlotSync = 4'd0;
  localparam logic [3:0] SlotLastBit = 4'd8;

  // Input item action codes
  typedef enum logic [1:0] {
    ActLoad   = 2'd0,
    ActStart  = 2'd1,
    ActSlot   = 2'd2,
    ActSample = 2'd3
  } action_e;

  // Finish status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StLost  = 2'd1,
    StSync  = 2'd2,
    StAbort = 2'd3
  } status_e;

endpackage

`default_nettype wire

FILE: rtl/core/bafs_in_if.sv
// ----------------------------------------------------------------------------
// bafs_in_if: input item channel
// Valid/ready channel carrying one command item for the frame sender.
// ----------------------------------------------------------------------------
`default_nettype none

interface bafs_in_if;
  import bafs_pkg::*;

  logic        valid;
  logic        ready;
  action_e     action;
  logic [3:0]  byte_index;
  logic [7:0]  tx_byte;
  logic [4:0]  frame_length;
  logic        line_level;
  logic        bus_granted;

  modport source (
    output valid, action, byte_index, tx_byte, frame_length, line_level, bus_granted,
    input  ready
  );

  modport sink (
    input  valid, action, byte_index, tx_byte, frame_length, line_level, bus_granted,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/bafs_out_if.sv
// ----------------------------------------------------------------------------
// bafs_out_if: result item channel
// Valid/ready channel carrying one result item from the frame sender.
// ----------------------------------------------------------------------------
`default_nettype none

interface bafs_out_if;
  import bafs_pkg::*;

  logic        valid;
  logic        ready;
  logic        drive_pulse;
  logic        byte_valid;
  logic [7:0]  bus_byte;
  logic [3:0]  bus_byte_index;
  logic        done_res;
  status_e     status;
  logic [4:0]  byte_count;

  modport source (
    output valid, drive_pulse, byte_valid, bus_byte, bus_byte_index, done_res, status,
           byte_count,
    input  ready
  );

  modport sink (
    input  valid, drive_pulse, byte_valid, bus_byte, bus_byte_index, done_res, status,
           byte_count,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/bafs_cfg_if.sv
// ----------------------------------------------------------------------------
// bafs_cfg_if: configuration write channel
// Valid/ready channel carrying the receive limit register write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface bafs_cfg_if;
  logic        valid;
  logic        ready;
  logic [4:0]  data;

  modport source (
    output valid, data,
    input  ready
  );

  modport sink (
    input  valid, data,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/bitwise_arbitration_frame_sender.sv
// ----------------------------------------------------------------------------
// bitwise_arbitration_frame_sender: bus frame transmitter with bitwise
// arbitration
// Loads frame bytes, then sends each byte as a sync slot plus eight data
// slots (LSB first), checking the sampled line for sync and arbitration.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result item, captured on acceptance in a
// registered output stage. A new item is taken in every cycle as long as the
// output register is empty or being drained in the same cycle, so the block
// sustains one item per clock; all work on an item is one pass of logic
// between the item port and the result register. The frame store is a small
// register file that is not cleared at reset: load every byte position a send
// will use before starting it. The receive limit register may be written at
// any time the block has no item in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module bitwise_arbitration_frame_sender (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bafs_in_if.sink    in_i,
  bafs_out_if.source out_o,
  bafs_cfg_if.sink   cfg_i
);
  import bafs_pkg::*;

  // Send state
  logic [7:0]        frame_store_q [MaxFrame];
  logic [7:0]        bus_shift_q, bus_shift_d;
  logic [CountW-1:0] byte_pos_q, byte_pos_d;
  logic [3:0]        slot_pos_q, slot_pos_d;
  logic              still_sending_q, still_sending_d;
  logic              active_q, active_d;
  logic              drove_one_q, drove_one_d;
  logic [CountW-1:0] send_length_q, send_length_d;
  logic [4:0]        rx_length_q;

  // Result register
  logic              out_valid_q;
  logic              drive_pulse_q, drive_pulse_d;
  logic              byte_valid_q, byte_valid_d;
  logic [7:0]        bus_byte_q, bus_byte_d;
  logic [3:0]        bus_byte_index_q, bus_byte_index_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [4:0]        byte_count_q, byte_count_d;

  // Combinational helpers
  logic              in_fire;
  logic              store_we;
  logic [31:0]       load_idx;
  logic [31:0]       rx_limit;
  logic [7:0]        cur_byte;
  logic [2:0]        bit_idx;
  logic [7:0]        shift_new;

  // Handshakes
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign load_idx = 32'(in_i.byte_index);
  assign rx_limit = (32'(rx_length_q) > MaxFrame) ? MaxFrame : 32'(rx_length_q);
  assign cur_byte = (32'(byte_pos_q) < MaxFrame) ?
                    frame_store_q[byte_pos_q[StoreIdxW-1:0]] : 8'd0;
  assign bit_idx  = 3'(slot_pos_q - 4'd1);

  // Item decode and state update
  always_comb begin
    bus_shift_d      = bus_shift_q;
    byte_pos_d       = byte_pos_q;
    slot_pos_d       = slot_pos_q;
    still_sending_d  = still_sending_q;
    active_d         = active_q;
    drove_one_d      = drove_one_q;
    send_length_d    = send_length_q;
    store_we         = 1'b0;
    shift_new        = bus_shift_q;
    drive_pulse_d    = 1'b0;
    byte_valid_d     = 1'b0;
    bus_byte_d       = 8'd0;
    bus_byte_index_d = 4'd0;
    done_d           = 1'b0;
    status_d         = StOk;
    byte_count_d     = 5'd0;

    case (in_i.action)
      ActLoad: begin
        store_we = (load_idx < MaxFrame);
      end

      ActStart: begin
        if (!active_q) begin
          send_length_d   = (32'(in_i.frame_length) > MaxFrame) ?
                            CountW'(MaxFrame) : CountW'(in_i.frame_length);
          byte_pos_d      = '0;
          slot_pos_d      = SlotSync;
          bus_shift_d     = 8'd0;
          still_sending_d = 1'b1;
          drove_one_d     = 1'b0;
          active_d        = 1'b1;
          if (send_length_d == '0) begin
            done_d       = 1'b1;
            status_d     = StOk;
            byte_count_d = 5'd0;
            active_d     = 1'b0;
          end
        end
      end

      default: begin
        // Slot start or mid-slot sample; ignored while idle
        if (active_q) begin
          if (!in_i.bus_granted) begin
            done_d       = 1'b1;
            status_d     = StAbort;
            byte_count_d = 5'(byte_pos_q);
            active_d     = 1'b0;
            drove_one_d  = 1'b0;
          end else if (in_i.action == ActSlot) begin
            // Sync slot always pulses while sending; data slots pulse on a one
            if (slot_pos_q == SlotSync || slot_pos_q > SlotLastBit) begin
              drive_pulse_d = still_sending_q;
            end else begin
              drive_pulse_d = still_sending_q && cur_byte[bit_idx];
            end
            drove_one_d = drive_pulse_d;
          end else if (slot_pos_q == SlotSync || slot_pos_q > SlotLastBit) begin
            // Sync sample: line must be high
            drove_one_d = 1'b0;
            if (!in_i.line_level) begin
              done_d       = 1'b1;
              status_d     = StSync;
              byte_count_d = 5'(byte_pos_q);
              active_d     = 1'b0;
            end else begin
              slot_pos_d = 4'd1;
            end
          end else begin
            // Data sample: record bit, check arbitration
            shift_new          = bus_shift_q;
            shift_new[bit_idx] = in_i.line_level;
            bus_shift_d        = shift_new;
            if (still_sending_q && (in_i.line_level != drove_one_q)) begin
              still_sending_d = 1'b0;
            end
            drove_one_d = 1'b0;
            slot_pos_d  = slot_pos_q + 4'd1;
            if (slot_pos_q == SlotLastBit) begin
              byte_valid_d     = 1'b1;
              bus_byte_d       = shift_new;
              bus_byte_index_d = 4'(byte_pos_q);
              byte_pos_d       = CountW'(byte_pos_q + 1'b1);
              slot_pos_d       = SlotSync;
              bus_shift_d      = 8'd0;
              if (still_sending_d) begin
                if (byte_pos_d >= send_length_q) begin
                  done_d       = 1'b1;
                  status_d     = StOk;
                  byte_count_d = 5'(byte_pos_d);
                  active_d     = 1'b0;
                end
              end else if (32'(byte_pos_d) >= rx_limit) begin
                done_d       = 1'b1;
                status_d     = StLost;
                byte_count_d = 5'(byte_pos_d);
                active_d     = 1'b0;
              end
            end
          end
        end
      end
    endcase
  end

  // Frame store, written by load items
  always_ff @(posedge clk_i) begin
    if (in_fire && store_we) begin
      frame_store_q[load_idx[StoreIdxW-1:0]] <= in_i.tx_byte;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_shift_q     <= 8'd0;
      byte_pos_q      <= '0;
      slot_pos_q      <= SlotSync;
      still_sending_q <= 1'b1;
      active_q        <= 1'b0;
      drove_one_q     <= 1'b0;
      send_length_q   <= '0;
      rx_length_q     <= RxLengthReset;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        rx_length_q <= cfg_i.data;
      end
      if (in_fire) begin
        bus_shift_q     <= bus_shift_d;
        byte_pos_q      <= byte_pos_d;
        slot_pos_q      <= slot_pos_d;
        still_sending_q <= still_sending_d;
        active_q        <= active_d;
        drove_one_q     <= drove_one_d;
        send_length_q   <= send_length_d;
        out_valid_q     <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      drive_pulse_q    <= drive_pulse_d;
      byte_valid_q     <= byte_valid_d;
      bus_byte_q       <= bus_byte_d;
      bus_byte_index_q <= bus_byte_index_d;
      done_q           <= done_d;
      status_q         <= status_d;
      byte_count_q     <= byte_count_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.drive_pulse    = drive_pulse_q;
  assign out_o.byte_valid     = byte_valid_q;
  assign out_o.bus_byte       = bus_byte_q;
  assign out_o.bus_byte_index = bus_byte_index_q;
  assign out_o.done_res       = done_q;
  assign out_o.status         = status_q;
  assign out_o.byte_count     = byte_count_q;

endmodule

`default_nettype wire

FILE: sim/bafs_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafs_frame_checker: scoreboard for the arbitration frame sender
// Watches the item, result and register channels, keeps its own model of the
// sender state, predicts one result per accepted item and compares the
// results field by field in order.
// ----------------------------------------------------------------------------

module bafs_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  bafs_in_if          in_mon_i,
  bafs_out_if         out_mon_i,
  bafs_cfg_if         cfg_mon_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import bafs_pkg::*;

  // One predicted result item
  typedef struct packed {
    logic       drive;
    logic       byte_done;
    logic [7:0] seen_byte;
    logic [3:0] seen_idx;
    logic       done;
    status_e    status;
    logic [4:0] count;
  } bus_result_t;

  // Sender state as the scoreboard sees it
  logic [7:0]  frame_mem [MaxFrame];
  logic [7:0]  shift_q    = 8'h00;
  int unsigned pos_byte   = 0;
  int unsigned pos_slot   = 0;
  bit          tx_on      = 1'b1;
  bit          busy       = 1'b0;
  bit          drove      = 1'b0;
  int unsigned len_send   = 0;
  logic [4:0]  rx_limit_q = RxLengthReset;

  bus_result_t results_due [$];
  int unsigned mismatches = 0;

  assign errors_o = mismatches;

  // Close the send with the given status
  function automatic void end_send(inout bus_result_t r, input status_e st);
    r.done   = 1'b1;
    r.status = st;
    r.count  = 5'(pos_byte);
    busy     = 1'b0;
    drove    = 1'b0;
  endfunction

  // Advance the model by one item and return its result
  function automatic bus_result_t predict_result(action_e act, logic [3:0] idx,
                                                 logic [7:0] data, logic [4:0] flen,
                                                 logic line, logic granted);
    bus_result_t r;
    int unsigned lim;
    logic [7:0]  cur;
    r = '0;
    cur = (pos_byte < MaxFrame) ? frame_mem[pos_byte] : 8'h00;
    if (act == ActLoad) begin
      if (idx < MaxFrame) frame_mem[idx] = data;
    end else if (act == ActStart) begin
      if (!busy) begin
        len_send = (flen > MaxFrame) ? MaxFrame : flen;
        pos_byte = 0;
        pos_slot = 0;
        shift_q  = 8'h00;
        tx_on    = 1'b1;
        drove    = 1'b0;
        busy     = 1'b1;
        if (len_send == 0) end_send(r, StOk);
      end
    end else if (!busy) begin
      // slot or sample while idle: nothing happens
    end else if (!granted) begin
      end_send(r, StAbort);
    end else if (act == ActSlot) begin
      if (pos_slot == 0 || pos_slot > 8) drove = tx_on;
      else drove = tx_on && cur[pos_slot-1];
      r.drive = drove;
    end else if (pos_slot == 0 || pos_slot > 8) begin
      // sync slot sample: line must be high
      drove = 1'b0;
      if (!line) end_send(r, StSync);
      else pos_slot = 1;
    end else begin
      // data bit sample, LSB first
      shift_q[pos_slot-1] = line;
      if (tx_on && (line != drove)) tx_on = 1'b0;
      drove = 1'b0;
      pos_slot++;
      if (pos_slot >= 9) begin
        r.byte_done = 1'b1;
        r.seen_byte = shift_q;
        r.seen_idx  = 4'(pos_byte);
        pos_byte++;
        pos_slot = 0;
        shift_q  = 8'h00;
        if (tx_on) begin
          if (pos_byte >= len_send) end_send(r, StOk);
        end else begin
          lim = (rx_limit_q > MaxFrame) ? MaxFrame : rx_limit_q;
          if (pos_byte >= lim) end_send(r, StLost);
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // Track register writes, check results, queue predictions
  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t want;
    if (!rst_ni) begin
      shift_q    = 8'h00;
      pos_byte   = 0;
      pos_slot   = 0;
      tx_on      = 1'b1;
      busy       = 1'b0;
      drove      = 1'b0;
      len_send   = 0;
      rx_limit_q = RxLengthReset;
      results_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) rx_limit_q = cfg_mon_i.data;

      if (out_mon_i.valid && out_mon_i.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none expected", $time);
        end else begin
          want = results_due.pop_front();
          check_field("drive_pulse", want.drive, out_mon_i.drive_pulse);
          check_field("byte_valid", want.byte_done, out_mon_i.byte_valid);
          check_field("bus_byte", want.seen_byte, out_mon_i.bus_byte);
          check_field("bus_byte_index", want.seen_idx, out_mon_i.bus_byte_index);
          check_field("done_res", want.done, out_mon_i.done_res);
          check_field("status", want.status, out_mon_i.status);
          check_field("byte_count", want.count, out_mon_i.byte_count);
        end
      end

      if (in_mon_i.valid && in_mon_i.ready) begin
        results_due.push_back(predict_result(in_mon_i.action, in_mon_i.byte_index,
                                             in_mon_i.tx_byte, in_mon_i.frame_length,
                                             in_mon_i.line_level, in_mon_i.bus_granted));
      end
      pending_o <= results_due.size();
    end
  end

endmodule

FILE: sim/bitwise_arbitration_frame_sender_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitwise_arbitration_frame_sender_tb: top of the frame sender testbench
// Drives load, start, slot and sample items as whole frames with random
// content, arbitration losses, sync failures and aborts, across several
// receive limits, with random gaps and a long output hold-off. The checker
// beside the block does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------

module bitwise_arbitration_frame_sender_tb;
  import bafs_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 270;
  localparam int unsigned PhaseCount  = 7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bafs_in_if  in_ch ();
  bafs_out_if out_ch ();
  bafs_cfg_if cfg_ch ();

  int unsigned errors;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned quiet      = 0;
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;
  logic [4:0]  rx_setting = RxLengthReset;
  logic [7:0]  frame_copy [MaxFrame];

  always #5 clk = ~clk;

  bitwise_arbitration_frame_sender i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  bafs_frame_checker i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_mon_i  (in_ch),
    .out_mon_i (out_ch),
    .cfg_mon_i (cfg_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("** bitwise_arbitration_frame_sender: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // Offer one item, with random gaps, and wait until it is taken
  task automatic push_item(action_e act, logic [3:0] idx, logic [7:0] data,
                           logic [4:0] flen, logic line, logic granted);
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.byte_index   <= idx;
    in_ch.tx_byte      <= data;
    in_ch.frame_length <= flen;
    in_ch.line_level   <= line;
    in_ch.bus_granted  <= granted;
    if (act == ActLoad) frame_copy[idx] = data;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Slot or sample item; the fields it does not use are random
  task automatic bus_event(action_e act, logic line, logic granted);
    push_item(act, 4'($urandom), 8'($urandom), 5'($urandom), line, granted);
  endtask

  task automatic load_random();
    push_item(ActLoad, 4'($urandom), 8'($urandom), 5'($urandom), 1'($urandom),
              1'($urandom));
  endtask

  // Register write, only with no item in flight
  task automatic write_limit(logic [4:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    rx_setting = value;
  endtask

  // One well-formed send: start, then sync and eight data slots per byte.
  // Line levels follow the sent bits unless arbitration is to be lost.
  task automatic run_frame();
    int unsigned sel, flen, eff, lim, lose_byte, lose_bit;
    bit          lose, lost;
    logic        sent, line;
    repeat ($urandom_range(2)) load_random();
    sel = $urandom_range(99);
    if (sel < 5) flen = 0;
    else if (sel < 10) flen = $urandom_range(17, 31);
    else if (sel < 25) flen = $urandom_range(5, 16);
    else flen = $urandom_range(1, 4);
    eff = (flen > MaxFrame) ? MaxFrame : flen;
    lim = (rx_setting > MaxFrame) ? MaxFrame : rx_setting;
    push_item(ActStart, 4'($urandom), 8'($urandom), 5'(flen), 1'($urandom),
              1'($urandom));
    if (eff == 0) return;
    lose      = ($urandom_range(99) < 25);
    lose_byte = $urandom_range(eff - 1);
    lose_bit  = $urandom_range(7);
    lost      = 1'b0;
    for (int b = 0; b < MaxFrame; b++) begin
      // abort on the slot start
      if ($urandom_range(99) < 2) begin
        bus_event(ActSlot, 1'($urandom), 1'b0);
        return;
      end
      bus_event(ActSlot, 1'($urandom), 1'b1);
      // sync failure
      if ($urandom_range(99) < 2) begin
        bus_event(ActSample, 1'b0, 1'b1);
        return;
      end
      bus_event(ActSample, 1'b1, 1'b1);
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(99) < 3) load_random();
        sent = !lost && frame_copy[b][k];
        // now and then a sample comes without its slot start
        if ($urandom_range(99) < 3) sent = 1'b0;
        else bus_event(ActSlot, 1'($urandom), 1'b1);
        line = lost ? 1'($urandom) : sent;
        if (!lost && lose && b == lose_byte && k == lose_bit) begin
          line = ~sent;
          lost = 1'b1;
        end
        // abort on a data sample
        if ($urandom_range(99) < 1) begin
          bus_event(ActSample, line, 1'b0);
          return;
        end
        bus_event(ActSample, line, 1'b1);
      end
      if (lost) begin
        if (b + 1 >= lim) return;
      end else if (b + 1 >= eff) begin
        return;
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned target;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ActLoad;
    in_ch.byte_index   <= 4'd0;
    in_ch.tx_byte      <= 8'h00;
    in_ch.frame_length <= 5'd0;
    in_ch.line_level   <= 1'b0;
    in_ch.bus_granted  <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= 5'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, idle items, empty frame, start while busy,
    // sync loss, abort, sample without slot start, saturated length
    push_item(ActLoad, 4'd0, 8'hFF, 5'd0, 1'b0, 1'b0);
    push_item(ActLoad, 4'd15, 8'h00, 5'd31, 1'b1, 1'b1);
    push_item(ActSlot, 4'd0, 8'h00, 5'd0, 1'b1, 1'b0);
    push_item(ActSample, 4'd15, 8'hFF, 5'd31, 1'b0, 1'b1);
    push_item(ActStart, 4'd0, 8'h00, 5'd0, 1'b0, 1'b1);
    push_item(ActStart, 4'd0, 8'h00, 5'd1, 1'b0, 1'b1);
    push_item(ActStart, 4'd0, 8'h00, 5'd31, 1'b0, 1'b1);
    push_item(ActSlot, 4'd0, 8'h00, 5'd0, 1'b0, 1'b1);
    push_item(ActSample, 4'd0, 8'h00, 5'd0, 1'b0, 1'b1);
    push_item(ActStart, 4'd0, 8'h00, 5'd1, 1'b1, 1'b0);
    push_item(ActSlot, 4'd0, 8'h00, 5'd0, 1'b1, 1'b0);
    push_item(ActStart, 4'd0, 8'h00, 5'd31, 1'b0, 1'b1);
    push_item(ActSample, 4'd0, 8'h00, 5'd0, 1'b1, 1'b1);
    push_item(ActSample, 4'd0, 8'h00, 5'd0, 1'b1, 1'b1);
    push_item(ActSample, 4'd0, 8'h00, 5'd0, 1'b1, 1'b0);

    // Fill the whole frame store before any random send
    for (int i = 0; i < MaxFrame; i++) begin
      push_item(ActLoad, 4'(i), 8'($urandom), 5'($urandom), 1'($urandom), 1'($urandom));
    end

    // Random frames under several receive limits
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        1:       write_limit(5'd1);
        2:       write_limit(5'd16);
        3:       write_limit(5'd31);
        4:       write_limit(5'd0);
        5:       write_limit(5'($urandom_range(2, 15)));
        6:       write_limit(5'($urandom));
        default: ;
      endcase
      calm = (phase == 2);
      if (phase == 3) hold_req = 1'b1;
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        if ($urandom_range(99) < 4) begin
          push_item(action_e'($urandom_range(3)), 4'($urandom), 8'($urandom),
                    5'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          run_frame();
        end
      end
    end
    calm = 1'b0;

    // Drain and decide
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** bitwise_arbitration_frame_sender: PASSED **");
    end else begin
      $display("** bitwise_arbitration_frame_sender: FAILED **");
    end
    $finish;
  end

endmodule
